>>> design/soft_knee_dynamics_gain_curve_macros.svh
// Assertion macros shared by the gain curve RTL.
// The macros expect a clock named clk and a synchronous reset named rst in scope.
`ifndef SOFT_KNEE_DYNAMICS_GAIN_CURVE_MACROS_SVH
`define SOFT_KNEE_DYNAMICS_GAIN_CURVE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define SKDGC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define SKDGC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> design/skdgc_pkg.sv
// Package for the soft-knee gain curve: register map, region codes and widths.
// No dependencies; used by the divider pipeline and the top level.
package skdgc_pkg;

  localparam int LEVEL_WIDTH_DEF = 16;
  localparam int THR_WIDTH       = 16;
  localparam int RATIO_WIDTH     = 16;
  localparam int KNEE_WIDTH      = 15;
  localparam int KNEE_E_WIDTH    = 16;
  localparam int DEN_WIDTH_DEF   = 34;
  localparam int NUM_MIN_WIDTH   = 49;
  localparam int QUOT_MIN_WIDTH  = 23;
  localparam int APB_ADDR_WIDTH  = 5;
  localparam int APB_DATA_WIDTH  = 32;

  localparam logic [RATIO_WIDTH-1:0]        RATIO_ONE     = 16'd256;
  localparam logic                          MODE_RESET    = 1'b1;
  localparam logic signed [THR_WIDTH-1:0]   THR_RESET     = 16'sd0;
  localparam logic [RATIO_WIDTH-1:0]        RATIO_RESET   = 16'd256;
  localparam logic [KNEE_WIDTH-1:0]         KNEE_RESET    = 15'd0;
  localparam logic signed [THR_WIDTH-1:0]   MAKEUP_RESET  = 16'sd0;
  localparam logic signed [THR_WIDTH-1:0]   RANGE_RESET   = -16'sd25600;

  typedef enum logic [1:0] {
    REGION_BELOW = 2'd0,
    REGION_KNEE  = 2'd1,
    REGION_ABOVE = 2'd2
  } region_t;

  typedef enum logic [2:0] {
    REG_MODE      = 3'd0,
    REG_THRESHOLD = 3'd1,
    REG_RATIO     = 3'd2,
    REG_KNEE      = 3'd3,
    REG_MAKEUP    = 3'd4,
    REG_RANGE     = 3'd5
  } reg_index_t;

endpackage

>>> design/skdgc_div_pipe.sv
// Pipelined restoring divider for the gain curve, one quotient bit per stage.
// Carries an opaque sideband word alongside each quotient; uses the shared macros.
`include "soft_knee_dynamics_gain_curve_macros.svh"

module skdgc_div_pipe #(
  parameter int NUM_WIDTH  = skdgc_pkg::NUM_MIN_WIDTH,
  parameter int DEN_WIDTH  = skdgc_pkg::DEN_WIDTH_DEF,
  parameter int QUOT_WIDTH = skdgc_pkg::QUOT_MIN_WIDTH + 1,
  parameter int SIDE_WIDTH = 8
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [NUM_WIDTH-1:0]  num,
  input  logic [DEN_WIDTH-1:0]  den,
  input  logic [SIDE_WIDTH-1:0] side,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [QUOT_WIDTH-1:0] quot,
  output logic [SIDE_WIDTH-1:0] side_out
);

  // The caller guarantees num >> QUOT_WIDTH < den, so the quotient fits.
  logic                  v    [QUOT_WIDTH];
  logic                  adv  [QUOT_WIDTH];
  logic [DEN_WIDTH-1:0]  rem  [QUOT_WIDTH];
  logic [QUOT_WIDTH-1:0] qn   [QUOT_WIDTH];
  logic [DEN_WIDTH-1:0]  dreg [QUOT_WIDTH];
  logic [SIDE_WIDTH-1:0] sreg [QUOT_WIDTH];

  for (genvar i = 0; i < QUOT_WIDTH; i++) begin : g_stage
    logic                  s_v;
    logic [DEN_WIDTH-1:0]  s_rem;
    logic [QUOT_WIDTH-1:0] s_qn;
    logic [DEN_WIDTH-1:0]  s_den;
    logic [SIDE_WIDTH-1:0] s_side;
    logic [DEN_WIDTH:0]    trial;
    logic                  ge;

    if (i == 0) begin : g_first
      assign s_v    = in_valid;
      assign s_rem  = DEN_WIDTH'(num >> QUOT_WIDTH);
      assign s_qn   = num[QUOT_WIDTH-1:0];
      assign s_den  = den;
      assign s_side = side;
    end else begin : g_rest
      assign s_v    = v[i-1];
      assign s_rem  = rem[i-1];
      assign s_qn   = qn[i-1];
      assign s_den  = dreg[i-1];
      assign s_side = sreg[i-1];
    end

    if (i == QUOT_WIDTH - 1) begin : g_last_adv
      assign adv[i] = !v[i] || out_ready;
    end else begin : g_mid_adv
      assign adv[i] = !v[i] || adv[i+1];
    end

    // Numerator bits leave qn at the top while quotient bits enter at the bottom.
    assign trial = {s_rem, s_qn[QUOT_WIDTH-1]};
    assign ge    = trial >= {1'b0, s_den};

    always_ff @(posedge clk) begin
      if (rst) begin
        v[i] <= 1'b0;
      end else if (adv[i]) begin
        v[i] <= s_v;
      end
    end

    always_ff @(posedge clk) begin
      if (adv[i]) begin
        rem[i]  <= ge ? DEN_WIDTH'(trial - {1'b0, s_den}) : trial[DEN_WIDTH-1:0];
        qn[i]   <= {s_qn[QUOT_WIDTH-2:0], ge};
        dreg[i] <= s_den;
        sreg[i] <= s_side;
      end
    end
  end

  assign in_ready  = adv[0];
  assign out_valid = v[QUOT_WIDTH-1];
  assign quot      = qn[QUOT_WIDTH-1];
  assign side_out  = sreg[QUOT_WIDTH-1];

  `SKDGC_ASSERT_NOW(a_den_nonzero, v[QUOT_WIDTH-1], dreg[QUOT_WIDTH-1] != '0, "divider saw zero divisor")
  `SKDGC_ASSERT_NOW(a_rem_bound, v[QUOT_WIDTH-1], rem[QUOT_WIDTH-1] < dreg[QUOT_WIDTH-1], "divider remainder not below divisor")
  `SKDGC_ASSERT_NOW(a_stall_full, !in_ready, v[0], "divider refused input with first stage empty")
  `SKDGC_ASSERT_NEXT(a_take_lands, in_valid && in_ready, v[0], "divider lost an accepted transaction")

endmodule

>>> design/soft_knee_dynamics_gain_curve.sv
// Soft-knee compressor/expander gain curve: maps an input level in dB (Q7.8) to
// an output level in dB with its curve region and a saturation flag. One
// transaction is accepted per clock while the output is not stalled, and results
// leave in order. Four front stages form the difference, the squares and the
// division operands, the restoring divider takes one stage per quotient bit, and
// three back stages apply the quotient, makeup or the range floor, and saturate.
// The user must write configuration over the APB port only while no transaction
// is in flight; the block itself does not enforce this.
`include "soft_knee_dynamics_gain_curve_macros.svh"

module soft_knee_dynamics_gain_curve #(
  parameter int LEVEL_WIDTH = skdgc_pkg::LEVEL_WIDTH_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [skdgc_pkg::APB_ADDR_WIDTH-1:0]  paddr,
  input  logic [skdgc_pkg::APB_DATA_WIDTH-1:0]  pwdata,
  output logic [skdgc_pkg::APB_DATA_WIDTH-1:0]  prdata,
  output logic                                  pready,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic signed [LEVEL_WIDTH-1:0]         level_in_db,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic signed [LEVEL_WIDTH-1:0]         level_out_db,
  output logic [1:0]                            curve_region,
  output logic                                  saturated
);
  import skdgc_pkg::*;

  localparam int DW = ((LEVEL_WIDTH > THR_WIDTH) ? LEVEL_WIDTH : THR_WIDTH) + 1;
  localparam int MW = DW + RATIO_WIDTH + 1;
  localparam int NW = ((DW + 9) > NUM_MIN_WIDTH) ? (DW + 9) : NUM_MIN_WIDTH;
  localparam int QW = ((DW > QUOT_MIN_WIDTH) ? DW : QUOT_MIN_WIDTH) + 1;
  localparam int YW = DW + 12;
  localparam int WRW = KNEE_WIDTH + RATIO_WIDTH;
  localparam int PW = 2 * KNEE_E_WIDTH + RATIO_WIDTH;
  localparam int SW = LEVEL_WIDTH + 2 + 1 + YW;

  localparam logic signed [LEVEL_WIDTH-1:0] LVL_MAX = {1'b0, {(LEVEL_WIDTH-1){1'b1}}};
  localparam logic signed [LEVEL_WIDTH-1:0] LVL_MIN = {1'b1, {(LEVEL_WIDTH-1){1'b0}}};
  localparam logic signed [YW:0] Y_HI =
    {{(YW+2-LEVEL_WIDTH){1'b0}}, {(LEVEL_WIDTH-1){1'b1}}};
  localparam logic signed [YW:0] Y_LO =
    {{(YW+2-LEVEL_WIDTH){1'b1}}, {(LEVEL_WIDTH-1){1'b0}}};

  // ---------------------------------------------------------------- registers
  logic                          compressor_mode;
  logic signed [THR_WIDTH-1:0]   threshold_db;
  logic [RATIO_WIDTH-1:0]        ratio;
  logic [KNEE_WIDTH-1:0]         knee_width_db;
  logic signed [THR_WIDTH-1:0]   makeup_db;
  logic signed [THR_WIDTH-1:0]   range_db;

  logic       cfg_write;
  reg_index_t cfg_index;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;
  assign cfg_index = reg_index_t'(paddr[APB_ADDR_WIDTH-1:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      compressor_mode <= MODE_RESET;
      threshold_db    <= THR_RESET;
      ratio           <= RATIO_RESET;
      knee_width_db   <= KNEE_RESET;
      makeup_db       <= MAKEUP_RESET;
      range_db        <= RANGE_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_MODE:      compressor_mode <= pwdata[0];
        REG_THRESHOLD: threshold_db    <= $signed(pwdata[THR_WIDTH-1:0]);
        REG_RATIO:     ratio           <= pwdata[RATIO_WIDTH-1:0];
        REG_KNEE:      knee_width_db   <= pwdata[KNEE_WIDTH-1:0];
        REG_MAKEUP:    makeup_db       <= $signed(pwdata[THR_WIDTH-1:0]);
        REG_RANGE:     range_db        <= $signed(pwdata[THR_WIDTH-1:0]);
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_index)
      REG_MODE:      prdata = APB_DATA_WIDTH'(compressor_mode);
      REG_THRESHOLD: prdata = APB_DATA_WIDTH'(threshold_db);
      REG_RATIO:     prdata = APB_DATA_WIDTH'(ratio);
      REG_KNEE:      prdata = APB_DATA_WIDTH'(knee_width_db);
      REG_MAKEUP:    prdata = APB_DATA_WIDTH'(makeup_db);
      REG_RANGE:     prdata = APB_DATA_WIDTH'(range_db);
      default:       prdata = '0;
    endcase
  end

  // Ratios below unity are clamped to unity.
  logic [RATIO_WIDTH-1:0] r_eff;
  logic [RATIO_WIDTH-1:0] r_m;

  assign r_eff = (ratio < RATIO_ONE) ? RATIO_ONE : ratio;
  assign r_m   = r_eff - RATIO_ONE;

  // ---------------------------------------------------------------- handshake
  logic va, vb, vc, vd, vf, vg, vh;
  logic adv_a, adv_b, adv_c, adv_d, adv_f, adv_g, adv_h;
  logic div_in_ready, div_out_valid;
  logic [QW-1:0] div_quot;
  logic [SW-1:0] div_side_in, div_side_out;

  assign adv_h    = !vh || out_ready;
  assign adv_g    = !vg || adv_h;
  assign adv_f    = !vf || adv_g;
  assign adv_d    = !vd || div_in_ready;
  assign adv_c    = !vc || adv_d;
  assign adv_b    = !vb || adv_c;
  assign adv_a    = !va || adv_b;
  assign in_ready = adv_a;

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
      vb <= 1'b0;
      vc <= 1'b0;
      vd <= 1'b0;
      vf <= 1'b0;
      vg <= 1'b0;
      vh <= 1'b0;
    end else begin
      if (adv_a) begin
        va <= in_valid;
      end
      if (adv_b) begin
        vb <= va;
      end
      if (adv_c) begin
        vc <= vb;
      end
      if (adv_d) begin
        vd <= vc;
      end
      if (adv_f) begin
        vf <= div_out_valid;
      end
      if (adv_g) begin
        vg <= vf;
      end
      if (adv_h) begin
        vh <= vg;
      end
    end
  end

  // ---------------------------------------------------------------- stage A
  // Difference to threshold, region decision and the knee offset magnitude.
  logic signed [DW-1:0]   x_ext, t_ext, d_c;
  logic signed [DW:0]     k_c, w_k;
  logic signed [DW+1:0]   e_m;
  region_t                region_c;

  assign x_ext = DW'(level_in_db);
  assign t_ext = DW'(threshold_db);
  assign d_c   = x_ext - t_ext;
  assign k_c   = (DW+1)'(d_c) <<< 1;
  assign w_k   = $signed((DW+1)'(knee_width_db));
  // Compressor knee uses k + W, expander knee uses W - k; inside the knee both land in [0, 2W].
  assign e_m   = compressor_mode ? ((DW+2)'(k_c) + (DW+2)'(w_k))
                                 : ((DW+2)'(w_k) - (DW+2)'(k_c));

  always_comb begin
    if (k_c < -w_k) begin
      region_c = REGION_BELOW;
    end else if (k_c >= w_k) begin
      region_c = REGION_ABOVE;
    end else begin
      region_c = REGION_KNEE;
    end
  end

  logic signed [LEVEL_WIDTH-1:0] a_x;
  logic signed [DW-1:0]          a_d;
  region_t                       a_region;
  logic [KNEE_E_WIDTH-1:0]       a_e;

  always_ff @(posedge clk) begin
    if (adv_a) begin
      a_x      <= level_in_db;
      a_d      <= d_c;
      a_region <= region_c;
      a_e      <= e_m[KNEE_E_WIDTH-1:0];
    end
  end

  // ---------------------------------------------------------------- stage B
  logic signed [LEVEL_WIDTH-1:0] b_x;
  logic signed [DW-1:0]          b_d;
  region_t                       b_region;
  logic [2*KNEE_E_WIDTH-1:0]     b_esq;
  logic [WRW-1:0]                b_wr;
  logic signed [MW-1:0]          b_dr;

  always_ff @(posedge clk) begin
    if (adv_b) begin
      b_x      <= a_x;
      b_d      <= a_d;
      b_region <= a_region;
      b_esq    <= (2*KNEE_E_WIDTH)'(a_e) * (2*KNEE_E_WIDTH)'(a_e);
      b_wr     <= WRW'(knee_width_db) * WRW'(r_eff);
      b_dr     <= MW'(a_d) * $signed(MW'(r_eff));
    end
  end

  // ---------------------------------------------------------------- stage C
  // Knee numerator and the rounded d*R/256 of the expander's lower branch.
  logic [MW-1:0]   dr_mag;
  logic [MW:0]     dr_sum;
  logic [MW-8:0]   dr_q;

  assign dr_mag = b_dr[MW-1] ? $unsigned(-b_dr) : $unsigned(b_dr);
  assign dr_sum = (MW+1)'(dr_mag) + (MW+1)'(RATIO_ONE >> 1);
  assign dr_q   = dr_sum[MW:8];

  logic signed [LEVEL_WIDTH-1:0] c_x;
  logic signed [DW-1:0]          c_d;
  region_t                       c_region;
  logic [WRW-1:0]                c_wr;
  logic [PW-1:0]                 c_p;
  logic signed [MW-7:0]          c_srq;

  always_ff @(posedge clk) begin
    if (adv_c) begin
      c_x      <= b_x;
      c_d      <= b_d;
      c_region <= b_region;
      c_wr     <= b_wr;
      c_p      <= PW'(b_esq) * PW'(r_m);
      c_srq    <= b_dr[MW-1] ? -$signed({1'b0, dr_q}) : $signed({1'b0, dr_q});
    end
  end

  // ---------------------------------------------------------------- stage D
  // Numerators carry half the divisor so the floor division rounds to nearest.
  logic [NW-1:0]            num_c;
  logic [DEN_WIDTH_DEF-1:0] den_c;
  logic [DEN_WIDTH_DEF-1:0] den_sel;
  logic signed [YW-1:0]     base_c;
  logic                     useq_c;

  always_comb begin
    num_c   = '0;
    den_sel = DEN_WIDTH_DEF'(1);
    useq_c  = 1'b0;
    base_c  = YW'(c_x);
    if (compressor_mode) begin
      case (c_region)
        REGION_ABOVE: begin
          num_c   = (NW'($unsigned(c_d)) << 8) + NW'(r_eff >> 1);
          den_sel = DEN_WIDTH_DEF'(r_eff);
          useq_c  = 1'b1;
          base_c  = YW'(threshold_db);
        end
        REGION_KNEE: begin
          num_c   = NW'(c_p) + (NW'(c_wr) << 2);
          den_sel = DEN_WIDTH_DEF'(c_wr) << 3;
          useq_c  = 1'b1;
        end
        default: ;
      endcase
    end else begin
      case (c_region)
        REGION_BELOW: begin
          base_c = YW'(threshold_db) + YW'(c_srq);
        end
        REGION_KNEE: begin
          num_c   = NW'(c_p) + (NW'(knee_width_db) << 10);
          den_sel = DEN_WIDTH_DEF'(knee_width_db) << 11;
          useq_c  = 1'b1;
        end
        default: ;
      endcase
    end
  end

  assign den_c = (den_sel == '0) ? DEN_WIDTH_DEF'(1) : den_sel;

  logic [NW-1:0]                 d_num;
  logic [DEN_WIDTH_DEF-1:0]      d_den;
  logic signed [YW-1:0]          d_base;
  logic                          d_useq;
  logic signed [LEVEL_WIDTH-1:0] d_x;
  region_t                       d_region;

  always_ff @(posedge clk) begin
    if (adv_d) begin
      d_num    <= num_c;
      d_den    <= den_c;
      d_base   <= base_c;
      d_useq   <= useq_c;
      d_x      <= c_x;
      d_region <= c_region;
    end
  end

  assign div_side_in = {d_x, d_region, d_useq, d_base};

  skdgc_div_pipe #(
    .NUM_WIDTH  (NW),
    .DEN_WIDTH  (DEN_WIDTH_DEF),
    .QUOT_WIDTH (QW),
    .SIDE_WIDTH (SW)
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (vd),
    .in_ready  (div_in_ready),
    .num       (d_num),
    .den       (d_den),
    .side      (div_side_in),
    .out_valid (div_out_valid),
    .out_ready (adv_f),
    .quot      (div_quot),
    .side_out  (div_side_out)
  );

  // ---------------------------------------------------------------- stage F
  logic signed [LEVEL_WIDTH-1:0] q_x;
  logic [1:0]                    q_region;
  logic                          q_useq;
  logic signed [YW-1:0]          q_base;
  logic signed [YW-1:0]          q_ext;

  assign {q_x, q_region, q_useq, q_base} = div_side_out;
  assign q_ext = $signed(YW'(div_quot));

  logic signed [LEVEL_WIDTH-1:0] f_x;
  region_t                       f_region;
  logic signed [YW-1:0]          f_y1;

  // Knee terms are never positive, the compressor's upper branch never negative.
  always_ff @(posedge clk) begin
    if (adv_f) begin
      f_x      <= q_x;
      f_region <= region_t'(q_region);
      if (!q_useq) begin
        f_y1 <= q_base;
      end else if (q_region == REGION_KNEE) begin
        f_y1 <= q_base - q_ext;
      end else begin
        f_y1 <= q_base + q_ext;
      end
    end
  end

  // ---------------------------------------------------------------- stage G
  logic signed [YW:0] y1_ext, floor_c, y2_c;

  assign y1_ext  = (YW+1)'(f_y1);
  assign floor_c = (YW+1)'(f_x) + (YW+1)'(range_db);
  assign y2_c    = compressor_mode ? (y1_ext + (YW+1)'(makeup_db))
                                   : ((y1_ext < floor_c) ? floor_c : y1_ext);

  region_t            g_region;
  logic signed [YW:0] g_y;

  always_ff @(posedge clk) begin
    if (adv_g) begin
      g_region <= f_region;
      g_y      <= y2_c;
    end
  end

  // ---------------------------------------------------------------- stage H
  always_ff @(posedge clk) begin
    if (adv_h) begin
      curve_region <= g_region;
      if (g_y > Y_HI) begin
        level_out_db <= LVL_MAX;
        saturated    <= 1'b1;
      end else if (g_y < Y_LO) begin
        level_out_db <= LVL_MIN;
        saturated    <= 1'b1;
      end else begin
        level_out_db <= g_y[LEVEL_WIDTH-1:0];
        saturated    <= 1'b0;
      end
    end
  end

  assign out_valid = vh;

  `SKDGC_ASSERT_NOW(a_sat_clip, out_valid && saturated, (level_out_db == LVL_MAX) || (level_out_db == LVL_MIN), "saturated result not at a rail")
  `SKDGC_ASSERT_NOW(a_in_stall, !in_ready, va, "input refused with first stage empty")
  `SKDGC_ASSERT_NEXT(a_in_land, in_valid && in_ready, va, "accepted transaction did not enter the pipeline")

endmodule

>>> sim/tb_top.sv
`timescale 1ns / 100ps
// Self-checking testbench for the soft-knee compressor/expander gain curve.
// Depends on skdgc_pkg and the top level soft_knee_dynamics_gain_curve.
module tb_top;
  import skdgc_pkg::*;

  localparam int LW = LEVEL_WIDTH_DEF;
  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASES = 10;
  localparam int ITEMS_PER_PHASE = 140;

  typedef struct packed {
    logic                 mode;
    logic signed [15:0]   thr;
    logic [15:0]          ratio;
    logic [14:0]          knee;
    logic signed [15:0]   makeup;
    logic signed [15:0]   gain_floor;
  } curve_cfg_t;

  typedef struct packed {
    logic signed [LW-1:0] y;
    region_t              region;
    logic                 sat;
  } level_result_t;

  typedef struct packed {
    curve_cfg_t           c;
    logic signed [LW-1:0] x;
    logic                 typed;
    level_result_t        res;
  } curve_row_t;

  localparam curve_cfg_t CFG_RESET = '{1'b1, 16'sd0, 16'd256, 15'd0, 16'sd0, -16'sd25600};

  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          psel = 1'b0;
  logic                          penable = 1'b0;
  logic                          pwrite = 1'b0;
  logic [APB_ADDR_WIDTH-1:0]     paddr = '0;
  logic [APB_DATA_WIDTH-1:0]     pwdata = '0;
  logic [APB_DATA_WIDTH-1:0]     prdata;
  logic                          pready;
  logic                          in_valid = 1'b0;
  logic                          in_ready;
  logic signed [LW-1:0]          level_in_db = '0;
  logic                          out_valid;
  logic                          out_ready = 1'b0;
  logic signed [LW-1:0]          level_out_db;
  logic [1:0]                    curve_region;
  logic                          saturated;

  curve_cfg_t      cur_cfg;
  level_result_t   expected_levels[$];
  curve_row_t      curve_rows[$];
  level_result_t   want;
  bit              no_idle = 1'b0;
  int              error_count = 0;
  int              cycle_count = 0;
  int              sent_count = 0;
  int              checked_count = 0;
  int              cfg_count = 0;
  int              sat_count = 0;
  int              region_seen[3] = '{0, 0, 0};

  soft_knee_dynamics_gain_curve dut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_ready(in_ready), .level_in_db(level_in_db),
    .out_valid(out_valid), .out_ready(out_ready), .level_out_db(level_out_db),
    .curve_region(curve_region), .saturated(saturated)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               expected_levels.size());
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Receiver stalls are decided once per cycle at the falling edge.
  always @(negedge clk) begin
    out_ready <= no_idle || ($urandom_range(99) >= 34);
  end

  task automatic report_mismatch(string what, longint got, longint exp_val);
    error_count++;
    $display("mismatch on result %0d: %s got %0d expected %0d", checked_count, what,
             got, exp_val);
  endtask

  // Division rounded to nearest, ties away from zero; the divisor is positive.
  function automatic longint div_round_away(longint n, longint d);
    longint mag;
    longint q;
    mag = (n < 0) ? -n : n;
    q = (mag + d / 2) / d;
    return (n < 0) ? -q : q;
  endfunction

  function automatic level_result_t predict_level(logic signed [LW-1:0] level);
    level_result_t res;
    longint x, t, w, r, dd, k, e, y;
    longint lo, hi;
    x = level;
    t = cur_cfg.thr;
    w = cur_cfg.knee;
    r = (cur_cfg.ratio < RATIO_ONE) ? 256 : cur_cfg.ratio;
    dd = x - t;
    k = 2 * dd;
    lo = -(longint'(1) <<< (LW - 1));
    hi = (longint'(1) <<< (LW - 1)) - 1;
    if (k < -w) res.region = REGION_BELOW;
    else if (k >= w) res.region = REGION_ABOVE;
    else res.region = REGION_KNEE;
    if (cur_cfg.mode) begin
      case (res.region)
        REGION_BELOW: y = x;
        REGION_ABOVE: y = t + div_round_away(dd * 256, r);
        default: begin
          e = k + w;
          y = x + div_round_away(e * e * (256 - r), 8 * w * r);
        end
      endcase
      y = y + longint'(cur_cfg.makeup);
    end else begin
      case (res.region)
        REGION_BELOW: y = t + div_round_away(dd * r, 256);
        REGION_ABOVE: y = x;
        default: begin
          e = k - w;
          y = x + div_round_away(e * e * (256 - r), 2048 * w);
        end
      endcase
      // The range floor is not a clip, so it leaves the saturation flag alone.
      if (y < x + longint'(cur_cfg.gain_floor)) y = x + longint'(cur_cfg.gain_floor);
    end
    res.sat = 1'b0;
    if (y < lo) begin
      y = lo;
      res.sat = 1'b1;
    end else if (y > hi) begin
      y = hi;
      res.sat = 1'b1;
    end
    res.y = y[LW-1:0];
    return res;
  endfunction

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (expected_levels.size() == 0) begin
        report_mismatch("unexpected result, level_out_db", level_out_db, 0);
      end else begin
        want = expected_levels.pop_front();
        if (level_out_db !== want.y) report_mismatch("level_out_db", level_out_db, want.y);
        if (curve_region !== want.region)
          report_mismatch("curve_region", curve_region, want.region);
        if (saturated !== want.sat) report_mismatch("saturated", saturated, want.sat);
        if (want.region <= REGION_ABOVE) region_seen[want.region]++;
        if (want.sat) sat_count++;
      end
      checked_count++;
    end
  end

  // Bits above the register width carry random junk, which the block must ignore.
  // Consecutive writes keep psel high and go straight back to the setup phase.
  task automatic apb_write(reg_index_t idx, logic [31:0] value, logic [31:0] mask);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= APB_ADDR_WIDTH'(int'(idx) * 4);
    pwdata <= (value & mask) | ($urandom & ~mask);
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (expected_levels.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic apply_config(curve_cfg_t c);
    wait_drained();
    apb_write(REG_MODE, 32'(c.mode), 32'h1);
    apb_write(REG_THRESHOLD, 32'(c.thr), 32'hFFFF);
    apb_write(REG_RATIO, 32'(c.ratio), 32'hFFFF);
    apb_write(REG_KNEE, 32'(c.knee), 32'h7FFF);
    apb_write(REG_MAKEUP, 32'(c.makeup), 32'hFFFF);
    apb_write(REG_RANGE, 32'(c.gain_floor), 32'hFFFF);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    cur_cfg = c;
    cfg_count++;
  endtask

  task automatic send_level(logic signed [LW-1:0] x, logic typed, level_result_t typed_res);
    while (!no_idle && $urandom_range(99) < 34) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    level_in_db <= x;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    expected_levels.push_back(typed ? typed_res : predict_level(x));
    sent_count++;
    @(negedge clk);
  endtask

  task automatic add_row(curve_cfg_t c, int x, logic typed, int y, region_t rg, logic sat);
    curve_row_t row;
    row.c = c;
    row.x = x[LW-1:0];
    row.typed = typed;
    row.res.y = y[LW-1:0];
    row.res.region = rg;
    row.res.sat = sat;
    curve_rows.push_back(row);
  endtask

  function automatic curve_cfg_t random_cfg();
    curve_cfg_t c;
    c.mode = 1'($urandom_range(1));
    case ($urandom_range(3))
      0: c.thr = 16'($urandom);
      default: c.thr = 16'($urandom_range(12800) - 10240);
    endcase
    case ($urandom_range(3))
      0: c.ratio = 16'($urandom);
      1: c.ratio = 16'($urandom_range(255));
      default: c.ratio = 16'($urandom_range(5120, 256));
    endcase
    case ($urandom_range(3))
      0: c.knee = '0;
      1: c.knee = 15'($urandom);
      default: c.knee = 15'($urandom_range(5120, 1));
    endcase
    case ($urandom_range(2))
      0: c.makeup = 16'($urandom);
      default: c.makeup = 16'($urandom_range(5120) - 1280);
    endcase
    case ($urandom_range(3))
      0: c.gain_floor = 16'($urandom);
      1: c.gain_floor = '0;
      default: c.gain_floor = 16'(-int'($urandom_range(32768)));
    endcase
    return c;
  endfunction

  // Most levels fall around the threshold so that the knee region is well exercised.
  function automatic logic signed [LW-1:0] random_level();
    longint span, v;
    span = cur_cfg.knee;
    case ($urandom_range(5))
      0: v = $signed(LW'($urandom));
      1: v = $urandom_range(1) ? 32767 : -32768;
      default: v = longint'(cur_cfg.thr) + longint'($urandom_range(32'(span + 512)))
                   - (span / 2 + 256);
    endcase
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return v[LW-1:0];
  endfunction

  initial begin
    curve_cfg_t c;
    curve_cfg_t mk_hi, mk_lo, low_ratio, max_ratio, soft_comp, big_knee;
    curve_cfg_t expander, exp_hard, pos_range, thr_hi, thr_lo;
    level_result_t none;

    none = '0;
    mk_hi = CFG_RESET;      mk_hi.makeup = 16'sd32767;
    mk_lo = CFG_RESET;      mk_lo.makeup = -16'sd32768;
    low_ratio = CFG_RESET;  low_ratio.ratio = 16'd0;
    max_ratio = CFG_RESET;  max_ratio.ratio = 16'hFFFF;
    soft_comp = '{1'b1, -16'sd5120, 16'd1024, 15'd2560, 16'sd0, -16'sd25600};
    big_knee = '{1'b1, 16'sd0, 16'hFFFF, 15'h7FFF, 16'sd512, -16'sd25600};
    expander = '{1'b0, -16'sd10240, 16'd512, 15'd1280, 16'sd0, -16'sd25600};
    exp_hard = '{1'b0, 16'sd0, 16'hFFFF, 15'd0, 16'sd0, 16'sd0};
    pos_range = '{1'b0, 16'sd0, 16'd256, 15'd0, 16'sd0, 16'sd32767};
    thr_hi = CFG_RESET;     thr_hi.thr = 16'sd32767;
    thr_lo = CFG_RESET;     thr_lo.thr = -16'sd32768;

    add_row(CFG_RESET, -32768, 1, -32768, REGION_BELOW, 0);
    add_row(CFG_RESET, 32767, 1, 32767, REGION_ABOVE, 0);
    add_row(CFG_RESET, 0, 1, 0, REGION_ABOVE, 0);
    add_row(CFG_RESET, -1, 1, -1, REGION_BELOW, 0);
    add_row(mk_hi, 32767, 1, 32767, REGION_ABOVE, 1);
    add_row(mk_hi, -32768, 1, -1, REGION_BELOW, 0);
    add_row(mk_lo, -32768, 1, -32768, REGION_BELOW, 1);
    add_row(low_ratio, 1000, 1, 1000, REGION_ABOVE, 0);
    add_row(max_ratio, 32767, 0, 0, REGION_ABOVE, 0);
    add_row(soft_comp, -6400, 1, -6400, REGION_KNEE, 0);
    add_row(soft_comp, -5120, 0, 0, REGION_KNEE, 0);
    add_row(soft_comp, -3840, 0, 0, REGION_ABOVE, 0);
    add_row(soft_comp, 0, 0, 0, REGION_ABOVE, 0);
    add_row(big_knee, -32768, 0, 0, REGION_KNEE, 0);
    add_row(big_knee, 32767, 0, 0, REGION_KNEE, 0);
    add_row(expander, -32768, 0, 0, REGION_BELOW, 0);
    add_row(expander, -10240, 0, 0, REGION_KNEE, 0);
    add_row(expander, -12000, 0, 0, REGION_BELOW, 0);
    add_row(expander, 0, 1, 0, REGION_ABOVE, 0);
    add_row(exp_hard, -32768, 1, -32768, REGION_BELOW, 0);
    add_row(pos_range, 32767, 1, 32767, REGION_ABOVE, 1);
    add_row(pos_range, -32768, 0, 0, REGION_BELOW, 0);
    add_row(thr_hi, -32768, 1, -32768, REGION_BELOW, 0);
    add_row(thr_lo, 32767, 1, 32767, REGION_ABOVE, 0);

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // The first rows run on the reset values, with no register written.
    cur_cfg = CFG_RESET;
    foreach (curve_rows[i]) begin
      if (curve_rows[i].c != cur_cfg) apply_config(curve_rows[i].c);
      send_level(curve_rows[i].x, curve_rows[i].typed, curve_rows[i].typed ? curve_rows[i].res
                                                                          : none);
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: c = '{1'b1, -16'sd32768, 16'hFFFF, 15'h7FFF, 16'sd32767, -16'sd32768};
        1: c = '{1'b0, 16'sd32767, 16'hFFFF, 15'h7FFF, -16'sd32768, 16'sd0};
        default: c = random_cfg();
      endcase
      apply_config(c);
      no_idle = (ph == 5);
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if (ph == 3 && n == 70) wait_drained();
        send_level(random_level(), 0, none);
      end
    end
    no_idle = 1'b0;

    wait_drained();
    repeat (40) @(posedge clk);
    $display("Sent %0d levels over %0d curve settings; %0d results checked.", sent_count,
             cfg_count, checked_count);
    $display("Regions below/knee/above: %0d/%0d/%0d, saturated results: %0d.",
             region_seen[0], region_seen[1], region_seen[2], sat_count);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

>>> soft_knee_dynamics_gain_curve.f
+incdir+design
design/skdgc_pkg.sv
design/skdgc_div_pipe.sv
design/soft_knee_dynamics_gain_curve.sv
sim/tb_top.sv
